### rtl/mtfm_pkg.sv
// ============================================================================
// mtfm_pkg
// Shared constants and types for the topic filter matcher.
// ============================================================================
package mtfm_pkg;

    localparam int MAX_SUBS = 8;
    localparam int MAX_LEN  = 128;

    localparam int SLOT_W  = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int CNT_W   = $clog2(MAX_SUBS + 1);
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int BLEN_W  = $clog2(MAX_LEN + 1);
    localparam int FADDR_W = $clog2(MAX_SUBS * MAX_LEN);
    localparam int MASK_W  = 8;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_TOPIC  = 1'b1;

    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_STORED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT,
        S_READ,
        S_CHECK,
        S_PLUS,
        S_DONE
    } state_t;

    // matcher control
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } walk_ctl_t;

endpackage

### rtl/mtfm_ram.sv
// ============================================================================
// mtfm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module mtfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/mtfm_walker.sv
// ============================================================================
// mtfm_walker
// Sequencer that walks each stored filter against the buffered topic,
// one character compare per step, using registered-read memory ports.
// ============================================================================
module mtfm_walker
    import mtfm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CNT_W-1:0]    filter_count,
    input  logic [POS_W-1:0]    topic_length,
    input  logic [POS_W-1:0]    flen_rd,
    input  logic [7:0]          fdata,
    input  logic [7:0]          fdata_nx,
    input  logic [7:0]          tdata,
    output logic [SLOT_W-1:0]   slot,
    output logic [POS_W:0]      fpos,
    output logic [POS_W:0]      tpos,
    output walk_ctl_t           ctl,
    output logic [MASK_W-1:0]   mask
);

    state_t              state_reg, state_next;
    logic [SLOT_W:0]     slot_reg, slot_next;
    logic [POS_W:0]      fi_reg, fi_next;
    logic [POS_W:0]      ti_reg, ti_next;
    logic [POS_W:0]      fl_reg, fl_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;

    logic [POS_W:0] tl;
    logic f_end, f1_end, t_end;
    logic hit, miss;
    logic [MASK_W-1:0] bit_sel;

    assign tl     = {1'b0, topic_length};
    assign f_end  = (fi_reg >= fl_reg);
    assign f1_end = (fi_reg + 1'b1 >= fl_reg);
    assign t_end  = (ti_reg >= tl);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            fi_reg    <= '0;
            ti_reg    <= '0;
            fl_reg    <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            fi_reg    <= fi_next;
            ti_reg    <= ti_next;
            fl_reg    <= fl_next;
            mask_reg  <= mask_next;
        end
    end

    always_comb
    begin
        bit_sel = '0;
        if (int'(slot_reg) < MASK_W)
        begin
            bit_sel[slot_reg[$clog2(MASK_W)-1:0]] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        fi_next    = fi_reg;
        ti_next    = ti_reg;
        fl_next    = fl_reg;
        mask_next  = mask_reg;
        hit        = 1'b0;
        miss       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    slot_next  = '0;
                    mask_next  = '0;
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                // flen read address is slot; data valid next cycle
                if ({1'b0, slot_reg} >= {1'b0, CNT_W'(filter_count)} ||
                    slot_reg >= MASK_W)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    fi_next    = '0;
                    ti_next    = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                fl_next    = {1'b0, flen_rd};
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // fdata = filter[fi], fdata_nx = filter[fi+1], tdata = topic[ti]
                if (f_end)
                begin
                    if (t_end) hit = 1'b1;
                    else       miss = 1'b1;
                end
                else if (fdata == CH_HASH)
                begin
                    hit = 1'b1;
                end
                else if (fdata == CH_SLASH && !f1_end && fdata_nx == CH_HASH && t_end)
                begin
                    hit = 1'b1;
                end
                else if (fdata == CH_PLUS)
                begin
                    fi_next    = fi_reg + 1'b1;
                    state_next = S_PLUS;
                end
                else if (t_end || fdata != tdata)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    fi_next    = fi_reg + 1'b1;
                    ti_next    = ti_reg + 1'b1;
                    state_next = S_READ;
                    fl_next    = fl_reg;
                end
            end
            S_PLUS:
            begin
                // skip topic level; fdata now = filter[fi] after '+'
                if (!t_end && tdata != CH_SLASH)
                begin
                    ti_next = ti_reg + 1'b1;
                    state_next = S_PLUS;
                end
                else if (f_end && t_end)
                begin
                    hit = 1'b1;
                end
                else if (f_end || t_end || fdata != tdata)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    fi_next    = fi_reg + 1'b1;
                    ti_next    = ti_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (hit || miss)
        begin
            if (hit) mask_next = mask_reg | bit_sel;
            slot_next  = slot_reg + 1'b1;
            state_next = S_SLOT;
        end
        // S_READ re-reads memories: keep fl when looping within a filter
        if (state_reg == S_READ && (fi_reg != '0 || ti_reg != '0))
        begin
            fl_next = fl_reg;
        end
    end

    assign slot      = slot_reg[SLOT_W-1:0];
    assign fpos      = fi_next;
    assign tpos      = ti_next;
    assign ctl.start = start;
    assign ctl.busy  = (state_reg != S_IDLE);
    assign ctl.done  = (state_reg == S_DONE);
    assign mask      = mask_reg;

endmodule

### rtl/mqtt_topic_filter_matcher_core.sv
// ============================================================================
// mqtt_topic_filter_matcher_core
// Subscription filter table and topic matcher.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall): opcode, char_code, last. Opcode 0
//   appends a filter byte, opcode 1 a topic byte. One byte per cycle is
//   taken while no match walk is running.
//   Output channel (out_valid/out_stall): match_mask, status. One response
//   for every request with last set: filter stored / table full / too long
//   appear the cycle after the last filter byte.
//   A last topic byte starts a walk over the stored filters in a shared
//   compare unit: a setup state (S_SLOT) per filter, a read and a check
//   state (S_READ, S_CHECK) per compare step including the final end check,
//   and a '+' state (S_PLUS) that skips the topic bytes of one level.
//   The block stalls input during a walk.
//   The response sits in an output register; while it is not taken the
//   block accepts further non-final bytes but holds off the next last byte.
//   Reset clears filter count and byte counters; the stores need no clear.
// ============================================================================
module mqtt_topic_filter_matcher_core
    import mtfm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [7:0]        char_code,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MASK_W-1:0] match_mask,
    output logic [1:0]        status
);

    logic [CNT_W-1:0]  fcount_reg, fcount_next;
    logic [BLEN_W-1:0] blen_reg, blen_next;
    logic [POS_W-1:0]  tlen_reg, tlen_next;
    logic              ovalid_reg, ovalid_next;
    logic [MASK_W-1:0] omask_reg, omask_next;
    logic [1:0]        ostat_reg, ostat_next;

    logic acc, out_free;
    logic walk_start;
    walk_ctl_t ctl;
    logic [SLOT_W-1:0] wslot;
    logic [POS_W:0] wfpos, wtpos;
    logic [MASK_W-1:0] wmask;

    logic f_we, t_we, l_we;
    logic [FADDR_W-1:0] f_waddr, f_raddr, f_raddr1;
    logic [7:0] fdata, fdata_nx, tdata;
    logic [POS_W-1:0] flen_rd;
    logic [POS_W-1:0] fpos_nx;

    assign out_free = !ovalid_reg || !out_stall;
    assign in_stall = ctl.busy || (last && !out_free);
    assign acc      = in_valid && !in_stall;
    assign walk_start = acc && opcode == OP_TOPIC && last;

    assign f_we    = acc && opcode == OP_FILTER && fcount_reg < MAX_SUBS &&
                     blen_reg < BLEN_W'(MAX_LEN - 1);
    assign f_waddr = FADDR_W'(fcount_reg) * FADDR_W'(MAX_LEN) + FADDR_W'(blen_reg);
    assign t_we    = acc && opcode == OP_TOPIC && tlen_reg < POS_W'(MAX_LEN - 1);
    assign l_we    = acc && opcode == OP_FILTER && last && fcount_reg < MAX_SUBS &&
                     blen_reg < BLEN_W'(MAX_LEN - 1);

    assign fpos_nx  = wfpos[POS_W-1:0] + 1'b1;
    assign f_raddr  = FADDR_W'(wslot) * FADDR_W'(MAX_LEN) + FADDR_W'(wfpos[POS_W-1:0]);
    assign f_raddr1 = FADDR_W'(wslot) * FADDR_W'(MAX_LEN) + FADDR_W'(fpos_nx);

    mtfm_ram #(.WIDTH(8), .DEPTH(MAX_SUBS * MAX_LEN)) u_fstore (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(char_code),
        .raddr(f_raddr), .rdata(fdata)
    );

    // second copy serves the look-ahead byte for the '/#' case
    mtfm_ram #(.WIDTH(8), .DEPTH(MAX_SUBS * MAX_LEN)) u_fstore_nx (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(char_code),
        .raddr(f_raddr1), .rdata(fdata_nx)
    );

    mtfm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_topic (
        .clk(clk), .we(t_we), .waddr(tlen_reg), .wdata(char_code),
        .raddr(wtpos[POS_W-1:0]), .rdata(tdata)
    );

    mtfm_ram #(.WIDTH(POS_W), .DEPTH(MAX_SUBS)) u_flen (
        .clk(clk), .we(l_we), .waddr(fcount_reg[SLOT_W-1:0]),
        .wdata(POS_W'(blen_reg + 1'b1)), .raddr(wslot), .rdata(flen_rd)
    );

    mtfm_walker u_walk (
        .clk(clk), .rst_n(rst_n), .start(walk_start),
        .filter_count(fcount_reg), .topic_length(t_we ? tlen_reg + 1'b1 : tlen_reg),
        .flen_rd(flen_rd), .fdata(fdata), .fdata_nx(fdata_nx), .tdata(tdata),
        .slot(wslot), .fpos(wfpos), .tpos(wtpos), .ctl(ctl), .mask(wmask)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= '0;
            blen_reg   <= '0;
            tlen_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            fcount_reg <= fcount_next;
            blen_reg   <= blen_next;
            tlen_reg   <= tlen_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        omask_reg <= omask_next;
        ostat_reg <= ostat_next;
    end

    // topic length is latched here at walk start for the hold check; tlen_reg clears after done
    logic [POS_W-1:0] tlen_walk_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_walk_reg <= '0;
        end
        else if (walk_start)
        begin
            tlen_walk_reg <= t_we ? tlen_reg + 1'b1 : tlen_reg;
        end
    end

    always_comb
    begin
        fcount_next = fcount_reg;
        blen_next   = blen_reg;
        tlen_next   = tlen_reg;
        ovalid_next = ovalid_reg && out_stall;
        omask_next  = omask_reg;
        ostat_next  = ostat_reg;
        if (acc && opcode == OP_FILTER)
        begin
            if (blen_reg < BLEN_W'(MAX_LEN)) blen_next = blen_reg + 1'b1;
            if (last)
            begin
                blen_next   = '0;
                ovalid_next = 1'b1;
                omask_next  = '0;
                if (fcount_reg >= MAX_SUBS)
                begin
                    ostat_next = ST_FULL;
                end
                else if (blen_reg >= BLEN_W'(MAX_LEN - 1))
                begin
                    ostat_next = ST_TOO_LONG;
                end
                else
                begin
                    ostat_next  = ST_STORED;
                    fcount_next = fcount_reg + 1'b1;
                end
            end
        end
        if (t_we && !walk_start)
        begin
            tlen_next = tlen_reg + 1'b1;
        end
        if (walk_start)
        begin
            tlen_next = t_we ? tlen_reg + 1'b1 : tlen_reg;
        end
        if (ctl.done)
        begin
            tlen_next   = '0;
            ovalid_next = 1'b1;
            omask_next  = wmask;
            ostat_next  = ST_MATCH;
        end
    end

    assign out_valid  = ovalid_reg;
    assign match_mask = omask_reg;
    assign status     = ostat_reg;

`ifndef SYNTHESIS
    a_no_walk_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.busy |-> !acc)
        else $error("request accepted during match walk");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= CNT_W'(MAX_SUBS))
        else $error("filter count overflow");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |=> out_valid)
        else $error("walk result lost");
    a_tlen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.busy && !ctl.done |=> tlen_reg == tlen_walk_reg)
        else $error("topic length changed during walk");
`endif

endmodule
